>>> src/interrupt_priority_dispatch_macros.svh
// Assertion macros shared by the interrupt dispatch RTL.
`ifndef INTERRUPT_PRIORITY_DISPATCH_MACROS_SVH
`define INTERRUPT_PRIORITY_DISPATCH_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define IPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define IPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ipd_pkg.sv
// Types and constants of the interrupt dispatch block.
package ipd_pkg;

  localparam int unsigned KindW   = 3;
  localparam int unsigned LineW   = 5;
  localparam int unsigned LineIdxW = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned AddrW   = 16;

  localparam logic [AddrW-1:0] VectorBase = 16'h0040;
  localparam logic [AddrW-1:0] PushBytes  = 16'd2;

  typedef enum logic [KindW-1:0] {
    KIND_BOUNDARY  = 3'd0,
    KIND_WR_FLAGS  = 3'd1,
    KIND_WR_ENABLE = 3'd2,
    KIND_EI        = 3'd3,
    KIND_DI        = 3'd4,
    KIND_HALT      = 3'd5
  } kind_e;

endpackage

>>> src/ipd_if.sv
// Valid/ready channel interfaces for event words and result words.
interface ipd_in_if import ipd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KindW-1:0]   kind;
  logic [LineW-1:0]   request_lines;
  logic [ByteW-1:0]   write_data;
  logic [AddrW-1:0]   program_counter;
  logic [AddrW-1:0]   stack_pointer;

  modport source (output valid, kind, request_lines, write_data, program_counter,
                  stack_pointer, input ready);
  modport sink   (input valid, kind, request_lines, write_data, program_counter,
                  stack_pointer, output ready);
endinterface

interface ipd_out_if import ipd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               taken;
  logic [AddrW-1:0]   vector;
  logic [ByteW-1:0]   push_high;
  logic [ByteW-1:0]   push_low;
  logic [AddrW-1:0]   new_stack_pointer;
  logic [LineW-1:0]   pending_flags;
  logic               master_enable;
  logic               halted_now;

  modport source (output valid, taken, vector, push_high, push_low, new_stack_pointer,
                  pending_flags, master_enable, halted_now, input ready);
  modport sink   (input valid, taken, vector, push_high, push_low, new_stack_pointer,
                  pending_flags, master_enable, halted_now, output ready);
endinterface

>>> src/interrupt_priority_dispatch.sv
// Interrupt controller: flag/enable registers, EI delay, halt and priority dispatch.
`include "interrupt_priority_dispatch_macros.svh"

// Takes event words and returns one result word per event, in order.
// An accepted word sits in the input register, and in the
// same pass that loads the result register the controller state (flags, enables,
// master enable, EI delay, halt) is updated and the lowest pending enabled line is
// picked by a five-input priority encoder. The result register is loaded from the
// input register. Throughput is one word per cycle as long as results are taken;
// the input register lets a new word in while a result waits.
module interrupt_priority_dispatch import ipd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ipd_in_if.sink    in_i,
  ipd_out_if.source out_o
);

  // input register
  logic               s1_valid_q;
  logic [KindW-1:0]   s1_kind_q;
  logic [LineW-1:0]   s1_req_q;
  logic [ByteW-1:0]   s1_data_q;
  logic [AddrW-1:0]   s1_pc_q;
  logic [AddrW-1:0]   s1_sp_q;

  // controller state
  logic [LineW-1:0]   flags_q, flags_d;
  logic [ByteW-1:0]   enable_q, enable_d;
  logic               master_q, master_d;
  logic               pending_q, pending_d;
  logic               halt_q, halt_d;

  // result register
  logic               out_valid_q;
  logic               taken_q, taken_d;
  logic [AddrW-1:0]   vector_q, vector_d;
  logic [ByteW-1:0]   push_high_q, push_high_d;
  logic [ByteW-1:0]   push_low_q, push_low_d;
  logic [AddrW-1:0]   nsp_q, nsp_d;

  logic               s1_adv;
  logic               in_acc;
  logic               boundary;
  logic [LineW-1:0]   flags_w;
  logic               master_w;
  logic               pending_w;
  logic               halt_w;
  logic               raise;
  logic [LineW-1:0]   ready_lines;
  logic [LineIdxW-1:0] line;
  logic               dispatch;

  assign s1_adv   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc   = in_i.valid && in_i.ready;

  assign boundary = (s1_kind_q == KIND_BOUNDARY) || (s1_kind_q == KIND_EI) ||
                    (s1_kind_q == KIND_DI) || (s1_kind_q == KIND_HALT);

  always_comb begin
    flags_w   = flags_q;
    enable_d  = enable_q;
    master_w  = master_q;
    pending_w = pending_q;
    halt_w    = halt_q;
    unique case (s1_kind_q)
      KIND_WR_FLAGS:  flags_w   = s1_data_q[LineW-1:0];
      KIND_WR_ENABLE: enable_d  = s1_data_q;
      KIND_EI:        pending_w = 1'b1;
      KIND_DI: begin
        master_w  = 1'b0;
        pending_w = 1'b0;
      end
      KIND_HALT:      halt_w    = 1'b1;
      default: ;
    endcase
    // request pulses latch and wake from halt
    flags_w = flags_w | s1_req_q;
    if (s1_req_q != '0) begin
      halt_w = 1'b0;
    end
    // EI takes effect at the boundary after the one that set it
    raise = boundary && pending_q && pending_w;
    if (raise) begin
      master_w  = 1'b1;
      pending_w = 1'b0;
    end
  end

  assign ready_lines = flags_w & enable_d[LineW-1:0];

  // lowest set line wins
  always_comb begin
    line = '0;
    for (int i = LineW - 1; i >= 0; i--) begin
      if (ready_lines[i]) begin
        line = LineIdxW'(i);
      end
    end
  end

  assign dispatch = boundary && master_w && (ready_lines != '0);

  always_comb begin
    flags_d     = flags_w;
    master_d    = master_w;
    pending_d   = pending_w;
    halt_d      = halt_w;
    taken_d     = 1'b0;
    vector_d    = '0;
    push_high_d = '0;
    push_low_d  = '0;
    nsp_d       = s1_sp_q;
    if (dispatch) begin
      flags_d     = flags_w & ~(LineW'(1) << line);
      master_d    = 1'b0;
      halt_d      = 1'b0;
      taken_d     = 1'b1;
      vector_d    = VectorBase + {{(AddrW-LineIdxW-3){1'b0}}, line, 3'b000};
      push_high_d = s1_pc_q[AddrW-1:ByteW];
      push_low_d  = s1_pc_q[ByteW-1:0];
      nsp_d       = s1_sp_q - PushBytes;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
      enable_q    <= '0;
      master_q    <= 1'b0;
      pending_q   <= 1'b0;
      halt_q      <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        flags_q     <= flags_d;
        enable_q    <= enable_d;
        master_q    <= master_d;
        pending_q   <= pending_d;
        halt_q      <= halt_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q <= in_i.kind;
      s1_req_q  <= in_i.request_lines;
      s1_data_q <= in_i.write_data;
      s1_pc_q   <= in_i.program_counter;
      s1_sp_q   <= in_i.stack_pointer;
    end
    if (s1_adv) begin
      taken_q     <= taken_d;
      vector_q    <= vector_d;
      push_high_q <= push_high_d;
      push_low_q  <= push_low_d;
      nsp_q       <= nsp_d;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.taken             = taken_q;
  assign out_o.vector            = vector_q;
  assign out_o.push_high         = push_high_q;
  assign out_o.push_low          = push_low_q;
  assign out_o.new_stack_pointer = nsp_q;
  assign out_o.pending_flags     = flags_q;
  assign out_o.master_enable     = master_q;
  assign out_o.halted_now        = halt_q;

  `IPD_ASSERT_NEXT(a_adv_gives_result, s1_adv, out_valid_q, "advanced word gave no result")
  `IPD_ASSERT_NOW(a_taken_drops_ime, out_valid_q && taken_q, !master_q && !halt_q,
                  "dispatch left master enable or halt set")
  `IPD_ASSERT_NOW(a_idle_outputs_zero, out_valid_q && !taken_q,
                  (vector_q == '0) && (push_high_q == '0) && (push_low_q == '0),
                  "no dispatch but vector or push bytes nonzero")
  `IPD_ASSERT_NOW(a_vector_range, out_valid_q && taken_q,
                  (vector_q[2:0] == 3'b000) && (vector_q >= 16'h0040) && (vector_q <= 16'h0060),
                  "dispatch vector out of range")

endmodule
